// File: rtl/core/q24_pkg.sv
// shared action codes and pipeline types for the fixed-point alu
`timescale 1ns / 1ps
package q24_pkg;

    typedef enum logic [3:0] {
        ACT_ADD      = 4'd0,
        ACT_SUB      = 4'd1,
        ACT_MUL      = 4'd2,
        ACT_DIV      = 4'd3,
        ACT_GT       = 4'd4,
        ACT_LT       = 4'd5,
        ACT_GE       = 4'd6,
        ACT_LE       = 4'd7,
        ACT_EQ       = 4'd8,
        ACT_NE       = 4'd9,
        ACT_MIN      = 4'd10,
        ACT_MAX      = 4'd11,
        ACT_INC      = 4'd12,
        ACT_DEC      = 4'd13,
        ACT_FROM_INT = 4'd14,
        ACT_TO_INT   = 4'd15
    } action_t;

    // which unit supplies the final value
    typedef enum logic [1:0] {
        SEL_SIDE = 2'd0,
        SEL_MUL  = 2'd1,
        SEL_DIV  = 2'd2
    } sel_t;

endpackage

// File: rtl/core/q24_8_fixed_point_alu.sv
// top level of the q24.8 fixed-point alu pipeline
//
// usage: s_ channel takes one beat per cycle while s_ready is high (action, operand_a, operand_b);
// m_ channel returns one beat per input beat, in order.
// every action travels the same pipe depth, set by the divider, which
// resolves one quotient bit per stage, so results stay ordered.
// throughput is one beat per cycle while m_ready is high.
// the whole pipe advances together; when m_ready is low and the output holds
// a beat, every stage freezes and s_ready drops, so nothing is lost or
// repeated.
// reset clears all valid bits; payload registers are not reset.
// a zero divisor gives value 0 and divide_by_zero set.
`timescale 1ns / 1ps
module q24_8_fixed_point_alu
    import q24_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [3:0]            s_action,
    input  logic signed [DATA_WIDTH-1:0] s_operand_a,
    input  logic signed [DATA_WIDTH-1:0] s_operand_b,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [DATA_WIDTH-1:0] m_value_out,
    output logic                  m_compare_true,
    output logic                  m_divide_by_zero
);
    localparam int W     = DATA_WIDTH;
    // divider depth: prep, W steps, sign fix
    localparam int DEPTH = W + 2;

    logic en;
    logic [DEPTH-1:0] vld_reg;
    logic             bubble;

    // side-band result for all non-mul/div actions, computed at entry
    logic [W-1:0] alu_val;
    logic         alu_cmp, lt_ab, lt_ba;
    action_t      act;

    logic [W-1:0] sv_reg [DEPTH];
    logic         sc_reg [DEPTH];
    logic         sz_reg [DEPTH];
    sel_t         sel_reg [DEPTH];

    logic [W-1:0] mul_p, div_q;
    logic [W-1:0] mul_d_reg [DEPTH-2];

    logic [W-1:0] out_val_reg;
    logic         out_cmp_reg, out_dz_reg, out_vld_reg;

    // stall only when the output beat is held and not taken
    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;
    assign bubble  = 1'b0;

    always_comb begin
        act     = action_t'(s_action);
        lt_ab   = $signed(s_operand_a) < $signed(s_operand_b);
        lt_ba   = $signed(s_operand_b) < $signed(s_operand_a);
        alu_val = '0;
        alu_cmp = 1'b0;
        unique case (act)
            ACT_ADD:      alu_val = s_operand_a + s_operand_b;
            ACT_SUB:      alu_val = s_operand_a - s_operand_b;
            ACT_MUL:      alu_val = '0;
            ACT_DIV:      alu_val = '0;
            ACT_GT:       alu_cmp = lt_ba;
            ACT_LT:       alu_cmp = lt_ab;
            ACT_GE:       alu_cmp = !lt_ab;
            ACT_LE:       alu_cmp = !lt_ba;
            ACT_EQ:       alu_cmp = s_operand_a == s_operand_b;
            ACT_NE:       alu_cmp = s_operand_a != s_operand_b;
            ACT_MIN:      alu_val = lt_ab ? s_operand_a : s_operand_b;
            ACT_MAX:      alu_val = lt_ba ? s_operand_a : s_operand_b;
            ACT_INC:      alu_val = s_operand_a + W'(1);
            ACT_DEC:      alu_val = s_operand_a - W'(1);
            ACT_FROM_INT: alu_val = s_operand_a << FRAC_BITS;
            ACT_TO_INT:   alu_val = W'(s_operand_a >>> FRAC_BITS);
            default:      alu_val = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], (s_valid | bubble)};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sv_reg[0]  <= alu_val;
            sc_reg[0]  <= alu_cmp;
            sz_reg[0]  <= (act == ACT_DIV) && (s_operand_b == '0);
            sel_reg[0] <= (act == ACT_MUL) ? SEL_MUL :
                          ((act == ACT_DIV) && (s_operand_b != '0)) ? SEL_DIV : SEL_SIDE;
            for (int i = 1; i < DEPTH; i++) begin
                sv_reg[i]  <= sv_reg[i-1];
                sc_reg[i]  <= sc_reg[i-1];
                sz_reg[i]  <= sz_reg[i-1];
                sel_reg[i] <= sel_reg[i-1];
            end
        end
    end

    q24_mul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk (aclk),
        .en   (en),
        .a    (s_operand_a),
        .b    (s_operand_b),
        .p    (mul_p)
    );

    // delay the product to line up with the divider output
    always_ff @(posedge aclk) begin
        if (en) begin
            mul_d_reg[0] <= mul_p;
            for (int i = 1; i < DEPTH - 2; i++) begin
                mul_d_reg[i] <= mul_d_reg[i-1];
            end
        end
    end

    q24_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
        .aclk (aclk),
        .en   (en),
        .a    (s_operand_a),
        .b    (s_operand_b),
        .q    (div_q)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_cmp_reg <= sc_reg[DEPTH-1];
            out_dz_reg  <= sz_reg[DEPTH-1];
            unique case (sel_reg[DEPTH-1])
                SEL_MUL: out_val_reg <= mul_d_reg[DEPTH-3];
                SEL_DIV: out_val_reg <= div_q;
                default: out_val_reg <= sv_reg[DEPTH-1];
            endcase
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_value_out      = out_val_reg;
    assign m_compare_true   = out_cmp_reg;
    assign m_divide_by_zero = out_dz_reg;
endmodule

// File: rtl/core/q24_mul.sv
// pipelined wrapping fixed-point multiplier, two register stages
`timescale 1ns / 1ps
module q24_mul #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic [DATA_WIDTH-1:0] p
);
    localparam int HW = DATA_WIDTH / 2;
    localparam int LW = DATA_WIDTH - HW;

    // low half of the product only: three partial products
    logic [DATA_WIDTH-1:0] ll_reg, lh_reg, hl_reg;
    logic [DATA_WIDTH-1:0] sum;
    logic [DATA_WIDTH-1:0] rnd;
    logic [DATA_WIDTH-1:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= DATA_WIDTH'(a[LW-1:0]) * DATA_WIDTH'(b[LW-1:0]);
            lh_reg <= DATA_WIDTH'(a[LW-1:0]) * DATA_WIDTH'(b[DATA_WIDTH-1:LW]);
            hl_reg <= DATA_WIDTH'(a[DATA_WIDTH-1:LW]) * DATA_WIDTH'(b[LW-1:0]);
        end
    end

    always_comb begin
        sum = ll_reg + ((lh_reg + hl_reg) << LW);
        rnd = sum + (DATA_WIDTH'(1) << (FRAC_BITS - 1));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= DATA_WIDTH'($signed(rnd) >>> FRAC_BITS);
        end
    end

    assign p = p_reg;
endmodule

// File: rtl/core/q24_div.sv
// pipelined signed divider, one quotient bit per stage
`timescale 1ns / 1ps
module q24_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic [DATA_WIDTH-1:0] q
);
    localparam int W = DATA_WIDTH;

    logic [W-1:0] half, n, nmag, dmag;
    logic         neg;

    // prep stage: scaled dividend plus rounding half, magnitudes
    logic [W-1:0] nm_reg [W+1];
    logic [W-1:0] rem_reg [W+1];
    logic [W-1:0] dm_reg [W+1];
    logic         ng_reg [W+1];
    logic [W-1:0] q_reg;

    always_comb begin
        half = b[W-1] ? (W'(0) - ((W'(0) - b) >> 1)) : (b >> 1);
        n    = (a << FRAC_BITS) + half;
        nmag = n[W-1] ? (W'(0) - n) : n;
        dmag = b[W-1] ? (W'(0) - b) : b;
        neg  = n[W-1] ^ b[W-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nm_reg[0]  <= nmag;
            rem_reg[0] <= '0;
            dm_reg[0]  <= dmag;
            ng_reg[0]  <= neg;
        end
    end

    // restoring step: nm shifts out the dividend and in the quotient
    for (genvar i = 0; i < W; i++) begin : g_step
        logic [W:0] trial;
        always_comb begin
            trial = {rem_reg[i], nm_reg[i][W-1]} - {1'b0, dm_reg[i]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1] <= trial[W] ? {rem_reg[i][W-2:0], nm_reg[i][W-1]}
                                         : trial[W-1:0];
                nm_reg[i+1]  <= {nm_reg[i][W-2:0], ~trial[W]};
                dm_reg[i+1]  <= dm_reg[i];
                ng_reg[i+1]  <= ng_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= ng_reg[W] ? (W'(0) - nm_reg[W]) : nm_reg[W];
        end
    end

    assign q = q_reg;
endmodule

// File: bench/tb.sv
// self-checking bench for the q24.8 fixed-point alu: random and directed beats, in-order compare
`timescale 1ns / 1ps
module tb;
    import q24_pkg::*;

    localparam int W = 32;
    localparam int FB = 8;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        action_t           act;
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
    } alu_op_t;

    typedef struct {
        logic signed [W-1:0] value;
        logic                cmp;
        logic                dz;
    } alu_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [3:0] s_action = '0;
    logic signed [W-1:0] s_operand_a = '0;
    logic signed [W-1:0] s_operand_b = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [W-1:0] m_value_out;
    logic m_compare_true;
    logic m_divide_by_zero;

    alu_op_t  pending_ops[$];
    alu_res_t expected_results[$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    int beat_count = 0;
    bit stim_done = 1'b0;
    bit calm = 1'b0;   // stretch with no idling on either side

    q24_8_fixed_point_alu #(.DATA_WIDTH(W), .FRAC_BITS(FB)) i_dut (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    // predicted alu result, written in signed arithmetic at the block width
    function automatic alu_res_t alu_predict(alu_op_t op);
        alu_res_t r;
        logic signed [W-1:0] p;
        logic signed [W-1:0] half;
        logic signed [W-1:0] num;
        logic [W-1:0] mag_n;
        logic [W-1:0] mag_d;
        logic [W-1:0] q;
        r.value = '0;
        r.cmp = 1'b0;
        r.dz = 1'b0;
        case (op.act)
            ACT_ADD: r.value = op.a + op.b;
            ACT_SUB: r.value = op.a - op.b;
            ACT_MUL: begin
                // wrapped product plus half an lsb, then arithmetic shift
                p = op.a * op.b;
                p = p + (W'(1) << (FB - 1));
                r.value = p >>> FB;
            end
            ACT_DIV: begin
                if (op.b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    // half divisor rounded toward zero, keeps its sign
                    mag_d = op.b[W-1] ? -op.b : op.b;
                    half = op.b[W-1] ? -(mag_d >> 1) : (mag_d >> 1);
                    num = (op.a <<< FB) + half;
                    mag_n = num[W-1] ? -num : num;
                    q = mag_n / mag_d;
                    r.value = (num[W-1] != op.b[W-1]) ? -q : q;
                end
            end
            ACT_GT:  r.cmp = op.a > op.b;
            ACT_LT:  r.cmp = op.a < op.b;
            ACT_GE:  r.cmp = op.a >= op.b;
            ACT_LE:  r.cmp = op.a <= op.b;
            ACT_EQ:  r.cmp = op.a == op.b;
            ACT_NE:  r.cmp = op.a != op.b;
            ACT_MIN: r.value = (op.a < op.b) ? op.a : op.b;  // ties give b
            ACT_MAX: r.value = (op.b < op.a) ? op.a : op.b;
            ACT_INC: r.value = op.a + 1;
            ACT_DEC: r.value = op.a - 1;
            ACT_FROM_INT: r.value = op.a <<< FB;
            default: r.value = op.a >>> FB;
        endcase
        return r;
    endfunction

    function automatic logic signed [W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return $signed(W'($urandom_range(0, 2048))) - 1024;
            4: return $signed(W'($urandom_range(0, 1 << 16))) - (1 << 15);
            5: return -1;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic add_op(action_t act, logic signed [W-1:0] a, logic signed [W-1:0] b);
        alu_op_t op;
        op.act = act;
        op.a = a;
        op.b = b;
        pending_ops.push_back(op);
    endtask

    // stimulus: directed corners first, then random beats
    initial begin
        action_t act;
        add_op(ACT_DIV, 32'sh0000_0100, 0);                   // zero divisor
        add_op(ACT_DIV, 32'sh8000_0000, 0);
        add_op(ACT_DIV, 32'sh0080_0000, -32'sh100);           // negative divisor
        add_op(ACT_DIV, 32'sh8000_0000, -1);                  // most negative over minus one
        add_op(ACT_DIV, -32'sh180, 32'sh200);
        add_op(ACT_ADD, 32'sh7fff_ffff, 1);                   // overflow wraps
        add_op(ACT_SUB, 32'sh8000_0000, 1);
        add_op(ACT_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff);
        add_op(ACT_MUL, -32'sh180, 32'sh180);
        add_op(ACT_GT, 32'sh8000_0000, 32'sh7fff_ffff);
        add_op(ACT_LT, 32'sh8000_0000, 32'sh7fff_ffff);
        add_op(ACT_GE, 5, 5);
        add_op(ACT_LE, 5, 5);
        add_op(ACT_EQ, -1, -1);
        add_op(ACT_NE, -1, 0);
        add_op(ACT_MIN, 7, 7);                                // tie gives b
        add_op(ACT_MAX, -3, -3);
        add_op(ACT_MIN, 32'sh8000_0000, 32'sh7fff_ffff);
        add_op(ACT_MAX, 32'sh8000_0000, 32'sh7fff_ffff);
        add_op(ACT_INC, 32'sh7fff_ffff, 32'sh1234);           // one raw lsb
        add_op(ACT_DEC, 32'sh8000_0000, -1);
        add_op(ACT_FROM_INT, 32'sh00ff_ffff, 0);
        add_op(ACT_FROM_INT, 32'sh8000_0001, 0);
        add_op(ACT_TO_INT, 32'sh8000_0000, 0);
        add_op(ACT_TO_INT, -32'sh1, 32'sh7fff_ffff);
        for (int i = 0; i < 1150; i++) begin
            act = action_t'($urandom_range(0, 15));
            add_op(act, pick_operand(), ($urandom_range(0, 15) == 0) ? '0 : pick_operand());
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // driver: one beat per cycle from the pending queue while s_ready is high, with random gaps
    always @(posedge aclk) begin
        bit hold;
        alu_op_t op;
        if (aresetn) begin
            beat_count <= beat_count + 1;
            calm <= (beat_count % 1500) >= 1100;
            if (!s_valid || s_ready) begin
                hold = !calm && ($urandom_range(0, 99) < 35);
                if (pending_ops.size() != 0 && !hold) begin
                    op = pending_ops.pop_front();
                    expected_results.push_back(alu_predict(op));
                    s_valid <= 1'b1;
                    s_action <= op.act;
                    s_operand_a <= op.a;
                    s_operand_b <= op.b;
                end else begin
                    s_valid <= 1'b0;
                    if (pending_ops.size() == 0) stim_done <= 1'b1;
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 35);
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        alu_res_t exp_r;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected result beat: value %h", m_value_out);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_value_out !== exp_r.value || m_compare_true !== exp_r.cmp
                            || m_divide_by_zero !== exp_r.dz) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display("mismatch: exp value %h cmp %b dz %b, got %h %b %b",
                                exp_r.value, exp_r.cmp, exp_r.dz,
                                m_value_out, m_compare_true, m_divide_by_zero);
                    end
                end
            end
        end
    end

    // end of run: drain, then allow the pipe depth for stray beats
    initial begin
        wait (aresetn);
        while (!(stim_done && !s_valid && expected_results.size() == 0)
                && idle_cycles < STALL_LIMIT)
            @(posedge aclk);
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb NOT OK");
        end else begin
            repeat (3 * W + 20) @(posedge aclk);
            if (mismatch_count == 0 && expected_results.size() == 0) begin
                $display("tb OK");
            end else begin
                $display("tb NOT OK");
            end
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/core/q24_pkg.sv
rtl/core/q24_mul.sv
rtl/core/q24_div.sv
rtl/core/q24_8_fixed_point_alu.sv
bench/tb.sv
